// ----- hw/rtl/dq_voltage_to_three_phase_duty_core_assert.svh -----
// Assertion macros for the checker file of the dq to duty core.
// Needs a clock i_clk and an active low reset i_rst_n in the scope of use.
`ifndef DQ_VOLTAGE_TO_THREE_PHASE_DUTY_CORE_ASSERT_SVH
`define DQ_VOLTAGE_TO_THREE_PHASE_DUTY_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DQD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DQD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/dqd_pkg.sv -----
// Package for the dq voltage to three phase duty core: widths, register
// indexes, fixed point constants, pipeline stage map and the duty rounding.
`timescale 1ns / 1ps

package dqd_pkg;

    localparam int IN_W   = 16;
    localparam int DUTY_W = 16;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_BUS_VOLTAGE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DUTY    = 2'd1;

    localparam logic [15:0] BUS_VOLTAGE_RST = 16'd3072;
    localparam logic [15:0] MAX_DUTY_RST    = 16'd62259;

    // 1.224745, 0.8164966, 0.4082483, 0.7071068 scaled by 2^16 (Q1.16)
    localparam logic [16:0]        LIMIT_GAIN = 17'd80265;
    localparam logic signed [17:0] COEF_A     = 18'sd53510;
    localparam logic signed [17:0] COEF_HALF  = 18'sd26755;
    localparam logic signed [17:0] COEF_B     = 18'sd46341;

    // Pipeline stage map
    localparam int DIV_BITS  = 31;
    localparam int SQRT_BITS = 31;
    localparam int SCL_BITS  = 16;
    localparam int ST_IN     = 0;
    localparam int ST_DIV    = ST_IN + 1;
    localparam int ST_SQR    = ST_DIV + DIV_BITS;
    localparam int ST_SUM    = ST_SQR + 1;
    localparam int ST_SQRT   = ST_SUM + 1;
    localparam int ST_SPROD  = ST_SQRT + SQRT_BITS;
    localparam int ST_SCL    = ST_SPROD + 1;
    localparam int ST_SEL    = ST_SCL + SCL_BITS;
    localparam int ST_ROT    = ST_SEL + 1;
    localparam int ST_ROTSUM = ST_ROT + 1;
    localparam int ST_PP     = ST_ROTSUM + 1;
    localparam int ST_PCOMB  = ST_PP + 1;
    localparam int ST_PHASE  = ST_PCOMB + 1;
    localparam int ST_DUTY   = ST_PHASE + 1;
    localparam int NSTG      = ST_DUTY + 1;

    typedef struct packed {
        logic                sgn_q;
        logic                sgn_d;
        logic                lim;
        logic signed [15:0]  cs;
        logic signed [15:0]  sn;
        logic [30:0]         nq;
        logic [30:0]         nd;
        logic [15:0]         rq;
        logic [15:0]         rd;
        logic [30:0]         aq;
        logic [30:0]         ad;
        logic [61:0]         sq_q;
        logic [61:0]         sq_d;
        logic [61:0]         sum;
        logic [32:0]         srem;
        logic [30:0]         root;
        logic [46:0]         pq;
        logic [46:0]         pd;
        logic [31:0]         xq;
        logic [31:0]         xd;
        logic [15:0]         qq;
        logic [15:0]         qd;
        logic signed [31:0]  uq;
        logic signed [31:0]  ud;
        logic signed [47:0]  m_cd;
        logic signed [47:0]  m_su;
        logic signed [47:0]  m_sd;
        logic signed [47:0]  m_cu;
        logic signed [47:0]  ua;
        logic signed [47:0]  ub;
        logic signed [41:0]  p_ah;
        logic signed [41:0]  p_al;
        logic signed [41:0]  p_hh;
        logic signed [41:0]  p_hl;
        logic signed [41:0]  p_bh;
        logic signed [41:0]  p_bl;
        logic signed [65:0]  pa;
        logic signed [65:0]  ph;
        logic signed [65:0]  pb;
        logic signed [65:0]  sa;
        logic signed [65:0]  sb;
        logic signed [65:0]  sc;
        logic [15:0]         da;
        logic [15:0]         db;
        logic [15:0]         dc;
    } t_pipe;

    typedef struct packed {
        logic        lim;
        logic [15:0] dc;
        logic [15:0] db;
        logic [15:0] da;
    } t_out;

    // Add one half plus rounding half, floor to Q0.16, saturate.
    function automatic logic [DUTY_W-1:0] sat_duty(input logic signed [65:0] s);
        logic signed [65:0] x;
        logic signed [65:0] q;
        x = s + (66'sd1 <<< 45) + (66'sd1 <<< 29);
        q = x >>> 30;
        if (q < 66'sd0) begin
            sat_duty = '0;
        end else if (q > 66'sd65535) begin
            sat_duty = '1;
        end else begin
            sat_duty = q[DUTY_W-1:0];
        end
    endfunction

endpackage

// ----- hw/rtl/dq_voltage_to_three_phase_duty_core.sv -----
// Channel  | dir | handshake                      | payload
// s_axis   | in  | i_s_axis_tvalid/o_s_axis_tready | tdata: vq, vd, cos, sin (16b each)
// m_axis   | out | o_m_axis_tvalid/i_m_axis_tready | tdata: duty a, b, c; tuser: limited
// cfg      | in  | i_cfg_valid/o_cfg_ready         | i_cfg_index, i_cfg_data (16b)
//
// One item per clock while no skid entry is held; an accepted item passes 89 stage
// registers, the first loaded at the accepting edge, then the output register that
// drives o_m_axis_tvalid; the bit-per-stage divider, square root and scaler set the depth.
// Reset (synchronous, active low) clears stage valid bits and restores registers.
// A stalled output fills a one-entry skid, then the whole pipeline holds.
// Depends on dqd_pkg.
`timescale 1ns / 1ps

module dq_voltage_to_three_phase_duty_core import dqd_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [63:0]          i_s_axis_tdata,  // vq_volts, vd_volts, cos_angle, sin_angle
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [47:0]          o_m_axis_tdata,  // duty_a, duty_b, duty_c
    output logic [0:0]           o_m_axis_tuser,  // limited
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]          i_cfg_data
);

    logic [15:0] r_bus_voltage;
    logic [15:0] r_max_duty;
    logic [15:0] r_maxm;
    logic [31:0] r_maxm_sq;
    logic [15:0] bus_eff;
    logic [14:0] duty_excess;
    logic [32:0] n_maxm_full;

    t_pipe       n_p [NSTG];
    t_pipe       r_p [NSTG];
    logic [NSTG-1:0] r_v;
    logic        en;

    t_out        pipe_out;
    t_out        r_out;
    t_out        r_skid;
    logic        r_out_vld;
    logic        r_skid_vld;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bus_voltage <= BUS_VOLTAGE_RST;
            r_max_duty    <= MAX_DUTY_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_BUS_VOLTAGE: r_bus_voltage <= i_cfg_data;
                CFG_MAX_DUTY:    r_max_duty    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign bus_eff     = (r_bus_voltage == 16'd0) ? 16'd1 : r_bus_voltage;
    assign duty_excess = r_max_duty[15] ? r_max_duty[14:0] : 15'd0;
    assign n_maxm_full = 33'(LIMIT_GAIN * duty_excess) + 33'd32768;

    // Limit radius follows config, registered in r_maxm and then squared into r_maxm_sq
    always_ff @(posedge i_clk) begin
        r_maxm    <= n_maxm_full[31:16];
        r_maxm_sq <= r_maxm * r_maxm;
    end

    assign en = !r_skid_vld;
    assign o_s_axis_tready = en;

    for (genvar k = 0; k < NSTG; k++) begin : g_stg
        if (k == ST_IN) begin : g_in
            logic [15:0] vq;
            logic [15:0] vd;
            logic [16:0] mq;
            logic [16:0] md;
            assign vq = i_s_axis_tdata[15:0];
            assign vd = i_s_axis_tdata[31:16];
            always_comb begin
                mq = vq[15] ? 17'(17'd0 - {vq[15], vq}) : {1'b0, vq};
                md = vd[15] ? 17'(17'd0 - {vd[15], vd}) : {1'b0, vd};
                n_p[k]       = '0;
                n_p[k].sgn_q = vq[15];
                n_p[k].sgn_d = vd[15];
                n_p[k].cs    = $signed(i_s_axis_tdata[47:32]);
                n_p[k].sn    = $signed(i_s_axis_tdata[63:48]);
                n_p[k].nq    = {mq[15:0], 15'd0};
                n_p[k].nd    = {md[15:0], 15'd0};
            end
        end else if (k < ST_SQR) begin : g_div
            localparam int B = DIV_BITS - 1 - (k - ST_DIV);
            logic [16:0] tq;
            logic [16:0] td;
            always_comb begin
                tq = {r_p[k-1].rq, r_p[k-1].nq[B]};
                td = {r_p[k-1].rd, r_p[k-1].nd[B]};
                n_p[k] = r_p[k-1];
                if (tq >= {1'b0, bus_eff}) begin
                    n_p[k].rq = 16'(tq - {1'b0, bus_eff});
                    n_p[k].aq = {r_p[k-1].aq[29:0], 1'b1};
                end else begin
                    n_p[k].rq = tq[15:0];
                    n_p[k].aq = {r_p[k-1].aq[29:0], 1'b0};
                end
                if (td >= {1'b0, bus_eff}) begin
                    n_p[k].rd = 16'(td - {1'b0, bus_eff});
                    n_p[k].ad = {r_p[k-1].ad[29:0], 1'b1};
                end else begin
                    n_p[k].rd = td[15:0];
                    n_p[k].ad = {r_p[k-1].ad[29:0], 1'b0};
                end
            end
        end else if (k == ST_SQR) begin : g_sqr
            always_comb begin
                n_p[k]      = r_p[k-1];
                n_p[k].sq_q = r_p[k-1].aq * r_p[k-1].aq;
                n_p[k].sq_d = r_p[k-1].ad * r_p[k-1].ad;
            end
        end else if (k == ST_SUM) begin : g_sum
            always_comb begin
                n_p[k]      = r_p[k-1];
                n_p[k].sum  = r_p[k-1].sq_q + r_p[k-1].sq_d;
                n_p[k].lim  = n_p[k].sum > {30'd0, r_maxm_sq};
                n_p[k].srem = '0;
                n_p[k].root = '0;
            end
        end else if (k < ST_SPROD) begin : g_sqrt
            localparam int H = 61 - 2 * (k - ST_SQRT);
            logic [34:0] rt;
            logic [34:0] tt;
            always_comb begin
                rt = {r_p[k-1].srem, r_p[k-1].sum[H -: 2]};
                tt = {2'b00, r_p[k-1].root, 2'b01};
                n_p[k] = r_p[k-1];
                if (rt >= tt) begin
                    n_p[k].srem = 33'(rt - tt);
                    n_p[k].root = {r_p[k-1].root[29:0], 1'b1};
                end else begin
                    n_p[k].srem = rt[32:0];
                    n_p[k].root = {r_p[k-1].root[29:0], 1'b0};
                end
            end
        end else if (k == ST_SPROD) begin : g_sprod
            logic [46:0] prq;
            logic [46:0] prd;
            always_comb begin
                prq = r_p[k-1].aq * r_maxm;
                prd = r_p[k-1].ad * r_maxm;
                n_p[k]    = r_p[k-1];
                n_p[k].pq = prq;
                n_p[k].pd = prd;
                n_p[k].xq = {1'b0, prq[46:16]};
                n_p[k].xd = {1'b0, prd[46:16]};
                n_p[k].qq = '0;
                n_p[k].qd = '0;
            end
        end else if (k < ST_SEL) begin : g_scl
            localparam int B = SCL_BITS - 1 - (k - ST_SCL);
            logic [31:0] tq;
            logic [31:0] td;
            logic [31:0] mg;
            always_comb begin
                mg = {1'b0, r_p[k-1].root};
                tq = {r_p[k-1].xq[30:0], r_p[k-1].pq[B]};
                td = {r_p[k-1].xd[30:0], r_p[k-1].pd[B]};
                n_p[k] = r_p[k-1];
                if (tq >= mg) begin
                    n_p[k].xq = tq - mg;
                    n_p[k].qq = {r_p[k-1].qq[14:0], 1'b1};
                end else begin
                    n_p[k].xq = tq;
                    n_p[k].qq = {r_p[k-1].qq[14:0], 1'b0};
                end
                if (td >= mg) begin
                    n_p[k].xd = td - mg;
                    n_p[k].qd = {r_p[k-1].qd[14:0], 1'b1};
                end else begin
                    n_p[k].xd = td;
                    n_p[k].qd = {r_p[k-1].qd[14:0], 1'b0};
                end
            end
        end else if (k == ST_SEL) begin : g_sel
            logic [30:0] mq;
            logic [30:0] md;
            always_comb begin
                mq = r_p[k-1].lim ? {15'd0, r_p[k-1].qq} : r_p[k-1].aq;
                md = r_p[k-1].lim ? {15'd0, r_p[k-1].qd} : r_p[k-1].ad;
                n_p[k]    = r_p[k-1];
                n_p[k].uq = r_p[k-1].sgn_q ? -$signed({1'b0, mq}) : $signed({1'b0, mq});
                n_p[k].ud = r_p[k-1].sgn_d ? -$signed({1'b0, md}) : $signed({1'b0, md});
            end
        end else if (k == ST_ROT) begin : g_rot
            always_comb begin
                n_p[k]      = r_p[k-1];
                n_p[k].m_cd = r_p[k-1].cs * r_p[k-1].ud;
                n_p[k].m_su = r_p[k-1].sn * r_p[k-1].uq;
                n_p[k].m_sd = r_p[k-1].sn * r_p[k-1].ud;
                n_p[k].m_cu = r_p[k-1].cs * r_p[k-1].uq;
            end
        end else if (k == ST_ROTSUM) begin : g_rotsum
            always_comb begin
                n_p[k]    = r_p[k-1];
                n_p[k].ua = r_p[k-1].m_cd - r_p[k-1].m_su;
                n_p[k].ub = r_p[k-1].m_sd + r_p[k-1].m_cu;
            end
        end else if (k == ST_PP) begin : g_pp
            // Split alpha and beta into a signed upper and unsigned lower part
            logic signed [23:0] ah;
            logic signed [24:0] al;
            logic signed [23:0] bh;
            logic signed [24:0] bl;
            always_comb begin
                ah = $signed(r_p[k-1].ua[47:24]);
                al = $signed({1'b0, r_p[k-1].ua[23:0]});
                bh = $signed(r_p[k-1].ub[47:24]);
                bl = $signed({1'b0, r_p[k-1].ub[23:0]});
                n_p[k]      = r_p[k-1];
                n_p[k].p_ah = ah * COEF_A;
                n_p[k].p_al = al * COEF_A;
                n_p[k].p_hh = ah * COEF_HALF;
                n_p[k].p_hl = al * COEF_HALF;
                n_p[k].p_bh = bh * COEF_B;
                n_p[k].p_bl = bl * COEF_B;
            end
        end else if (k == ST_PCOMB) begin : g_pcomb
            always_comb begin
                n_p[k]    = r_p[k-1];
                n_p[k].pa = (66'(r_p[k-1].p_ah) <<< 24) + 66'(r_p[k-1].p_al);
                n_p[k].ph = (66'(r_p[k-1].p_hh) <<< 24) + 66'(r_p[k-1].p_hl);
                n_p[k].pb = (66'(r_p[k-1].p_bh) <<< 24) + 66'(r_p[k-1].p_bl);
            end
        end else if (k == ST_PHASE) begin : g_phase
            always_comb begin
                n_p[k]    = r_p[k-1];
                n_p[k].sa = r_p[k-1].pa;
                n_p[k].sb = r_p[k-1].pb - r_p[k-1].ph;
                n_p[k].sc = 66'sd0 - r_p[k-1].ph - r_p[k-1].pb;
            end
        end else begin : g_duty
            always_comb begin
                n_p[k]    = r_p[k-1];
                n_p[k].da = sat_duty(r_p[k-1].sa);
                n_p[k].db = sat_duty(r_p[k-1].sb);
                n_p[k].dc = sat_duty(r_p[k-1].sc);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[NSTG-2:0], i_s_axis_tvalid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p <= n_p;
        end
    end

    assign pipe_out = '{lim: r_p[ST_DUTY].lim, dc: r_p[ST_DUTY].dc,
                        db: r_p[ST_DUTY].db, da: r_p[ST_DUTY].da};

    // Output register plus one skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (!r_skid_vld) begin
            if (!r_out_vld || i_m_axis_tready) begin
                r_out_vld <= r_v[ST_DUTY];
            end else if (r_v[ST_DUTY]) begin
                r_skid_vld <= 1'b1;
            end
        end else if (i_m_axis_tready) begin
            r_skid_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_vld) begin
            if (!r_out_vld || i_m_axis_tready) begin
                r_out <= pipe_out;
            end else if (r_v[ST_DUTY]) begin
                r_skid <= pipe_out;
            end
        end else if (i_m_axis_tready) begin
            r_out <= r_skid;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {r_out.dc, r_out.db, r_out.da};
    assign o_m_axis_tuser  = r_out.lim;

endmodule

// ----- hw/rtl/dqd_assert_chk.sv -----
// Port-level checker for the dq to duty core, bound to the top level.
// Depends on the assertion macro header.
`timescale 1ns / 1ps
`include "dq_voltage_to_three_phase_duty_core_assert.svh"

module dqd_assert_chk (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_s_axis_tready,
    input logic                 o_m_axis_tvalid,
    input logic                 i_m_axis_tready,
    input logic [47:0]          o_m_axis_tdata,  // duty_a, duty_b, duty_c
    input logic [0:0]           o_m_axis_tuser,  // limited
    input logic                 i_cfg_valid,
    input logic                 o_cfg_ready
);

    logic        out_stall;
    logic [48:0] out_word;

    assign out_stall = o_m_axis_tvalid && !i_m_axis_tready;
    assign out_word  = {o_m_axis_tuser, o_m_axis_tdata};

    // Input side blocks only when a result is already waiting
    `DQD_ASSERT_NOW(a_ready_when_empty, !o_m_axis_tvalid, o_s_axis_tready, "input stalled")
    // Output taken: skid drains, input side open next cycle
    `DQD_ASSERT_NEXT(a_ready_after_take, i_m_axis_tready, o_s_axis_tready, "input not reopened")
    `DQD_ASSERT_NEXT(a_out_hold, out_stall, o_m_axis_tvalid && $stable(out_word), "item changed")
    `DQD_ASSERT_NOW(a_cfg_ready, i_cfg_valid, o_cfg_ready, "config write refused")

endmodule

bind dq_voltage_to_three_phase_duty_core dqd_assert_chk u_dqd_assert_chk (.*);

// ----- bench/tb_top.sv -----
// Self-checking bench for dq_voltage_to_three_phase_duty_core: random and directed
// dq commands, own duty predictor, random idling on both stream sides.
// Depends on dqd_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_top;
    import dqd_pkg::*;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic                 o_s_axis_tready;
    logic [63:0]          i_s_axis_tdata = '0;  // vq, vd, cos, sin
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready = 1'b0;
    logic [47:0]          o_m_axis_tdata;       // duty a, b, c
    logic [0:0]           o_m_axis_tuser;       // limited
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_BUS_VOLTAGE;
    logic [15:0]          i_cfg_data = '0;

    localparam int LATENCY = 100;

    t_out        duty_expected[$];
    logic [15:0] bus_cfg;
    logic [15:0] duty_cap_cfg;
    int          tx_idle;
    int          rx_idle;
    int          fail_count;
    longint      cycle_count;
    longint      hold_until;

    dq_voltage_to_three_phase_duty_core dut (.*);

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    always @(posedge i_clk) begin
        if (cycle_count < hold_until) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= rx_idle);
        end
    end

    function automatic longint unsigned root_floor(input longint unsigned x);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= res + b) begin
                x -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic longint norm_cmd(input longint v, input longint bus);
        longint m;
        m = (v < 0) ? -v : v;
        m = (m * 32768) / bus;
        return (v < 0) ? -m : m;
    endfunction

    function automatic longint shrink(input longint u, input longint maxm, input longint mag);
        longint m;
        m = (u < 0) ? -u : u;
        m = (m * maxm) / mag;
        return (u < 0) ? -m : m;
    endfunction

    function automatic logic [15:0] to_duty(input longint acc);
        longint q;
        q = (acc + (64'sd1 <<< 45) + (64'sd1 <<< 29)) >>> 30;
        if (q < 0) return 16'd0;
        if (q > 65535) return 16'hFFFF;
        return q[15:0];
    endfunction

    function automatic t_out predict_duties(input logic [63:0] d);
        longint vq, vd, c, s, bus, md, maxm, uq, ud, ua, ub, mag;
        longint unsigned sum;
        t_out r;
        vq = longint'($signed(d[15:0]));
        vd = longint'($signed(d[31:16]));
        c  = longint'($signed(d[47:32]));
        s  = longint'($signed(d[63:48]));
        bus = (bus_cfg == 0) ? 1 : longint'(bus_cfg);
        md = (duty_cap_cfg < 16'd32768) ? 32768 : longint'(duty_cap_cfg);
        maxm = (80265 * (md - 32768) + 32768) >> 16;
        uq = norm_cmd(vq, bus);
        ud = norm_cmd(vd, bus);
        sum = longint'(uq * uq) + longint'(ud * ud);
        r.lim = 1'b0;
        if (sum > longint'(maxm * maxm)) begin
            mag = longint'(root_floor(sum));
            uq = shrink(uq, maxm, mag);
            ud = shrink(ud, maxm, mag);
            r.lim = 1'b1;
        end
        ua = c * ud - s * uq;
        ub = s * ud + c * uq;
        r.da = to_duty(53510 * ua);
        r.db = to_duty(-26755 * ua + 46341 * ub);
        r.dc = to_duty(-26755 * ua - 46341 * ub);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out e;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (duty_expected.size() == 0) begin
                $error("unexpected item: duties %h", o_m_axis_tdata);
                fail_count++;
            end else begin
                e = duty_expected.pop_front();
                if (o_m_axis_tdata[15:0] !== e.da) begin
                    $error("duty_a expected %0d actual %0d", e.da, o_m_axis_tdata[15:0]);
                    fail_count++;
                end
                if (o_m_axis_tdata[31:16] !== e.db) begin
                    $error("duty_b expected %0d actual %0d", e.db, o_m_axis_tdata[31:16]);
                    fail_count++;
                end
                if (o_m_axis_tdata[47:32] !== e.dc) begin
                    $error("duty_c expected %0d actual %0d", e.dc, o_m_axis_tdata[47:32]);
                    fail_count++;
                end
                if (o_m_axis_tuser[0] !== e.lim) begin
                    $error("limited expected %0d actual %0d", e.lim, o_m_axis_tuser[0]);
                    fail_count++;
                end
            end
        end
    end

    task automatic send_cmd(input logic [15:0] vq, input logic [15:0] vd,
                            input logic [15:0] c, input logic [15:0] s);
        while ($urandom_range(99) < tx_idle) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {s, c, vd, vq};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        duty_expected.push_back(predict_duties(i_s_axis_tdata));
    endtask

    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (duty_expected.size() != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_BUS_VOLTAGE) bus_cfg = val;
        else duty_cap_cfg = val;
    endtask

    // Mostly commands near the bus range with unit-ish angles, some raw noise.
    task automatic send_random(input int n);
        int span;
        for (int k = 0; k < n; k++) begin
            span = (bus_cfg < 16'd8) ? 16 : int'(bus_cfg) * 2;
            if (span > 32767) span = 32767;
            case ($urandom_range(3))
                0: send_cmd(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
                1: send_cmd(16'($urandom_range(2 * span) - span),
                            16'($urandom_range(2 * span) - span),
                            16'($urandom_range(32768) - 16384),
                            16'($urandom_range(32768) - 16384));
                default: send_cmd(16'($urandom_range(span) - span / 2),
                                  16'($urandom_range(span) - span / 2),
                                  16'($urandom_range(32768) - 16384),
                                  16'($urandom_range(32768) - 16384));
            endcase
        end
    endtask

    task automatic test_directed();
        send_cmd(16'h0000, 16'h0000, 16'h4000, 16'h0000);
        send_cmd(16'h7FFF, 16'h0000, 16'h4000, 16'h0000);
        send_cmd(16'h8000, 16'h0000, 16'h4000, 16'h0000);
        send_cmd(16'h0000, 16'h7FFF, 16'h0000, 16'h4000);
        send_cmd(16'h0000, 16'h8000, 16'hC000, 16'h0000);
        send_cmd(16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_cmd(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_cmd(16'h0100, 16'hFF00, 16'h2D41, 16'h2D41);
        send_cmd(16'h0001, 16'hFFFF, 16'h4000, 16'hC000);
        send_cmd(16'h0400, 16'h0000, 16'h0000, 16'hC000);
        // Zero bus voltage acts as the smallest bus.
        write_reg(CFG_BUS_VOLTAGE, 16'd0);
        send_cmd(16'h0001, 16'h0000, 16'h4000, 16'h0000);
        send_cmd(16'h0000, 16'h0000, 16'h4000, 16'h4000);
        write_reg(CFG_BUS_VOLTAGE, 16'hFFFF);
        send_cmd(16'h7FFF, 16'h8000, 16'h4000, 16'h0000);
        send_cmd(16'h0000, 16'h0000, 16'h4000, 16'h0000);
        // Duty cap below one half: any nonzero vector collapses to zero.
        write_reg(CFG_MAX_DUTY, 16'd1000);
        send_cmd(16'h0001, 16'h0000, 16'h4000, 16'h0000);
        send_cmd(16'h0000, 16'h0000, 16'h4000, 16'h0000);
        write_reg(CFG_MAX_DUTY, 16'hFFFF);
        send_cmd(16'h7FFF, 16'h0000, 16'h4000, 16'h0000);
        write_reg(CFG_MAX_DUTY, 16'd32768);
        send_cmd(16'h0010, 16'h0010, 16'h4000, 16'h0000);
        write_reg(CFG_BUS_VOLTAGE, 16'd3072);
        write_reg(CFG_MAX_DUTY, 16'd62259);
    endtask

    task automatic test_config_sweep();
        logic [15:0] buses[5] = '{16'd1, 16'd256, 16'd3072, 16'd40000, 16'hFFFF};
        logic [15:0] caps[5]  = '{16'd0, 16'd32768, 16'd49152, 16'd62259, 16'hFFFF};
        for (int k = 0; k < 5; k++) begin
            write_reg(CFG_BUS_VOLTAGE, buses[k]);
            write_reg(CFG_MAX_DUTY, caps[(k + 2) % 5]);
            send_random(40);
        end
    endtask

    task automatic test_idle_phases();
        tx_idle = 36; rx_idle = 80;
        send_random(300);
        write_reg(CFG_BUS_VOLTAGE, 16'($urandom_range(65535, 1)));
        write_reg(CFG_MAX_DUTY, 16'($urandom_range(65535, 32768)));
        tx_idle = 80; rx_idle = 36;
        send_random(250);
        write_reg(CFG_BUS_VOLTAGE, 16'd3072);
        tx_idle = 0; rx_idle = 0;
        send_random(200);
    endtask

    // Hold the output long enough that the pipeline fills and stalls its input.
    task automatic test_backpressure();
        tx_idle = 0; rx_idle = 20;
        hold_until = cycle_count + 400;
        send_random(150);
    endtask

    initial begin
        bus_cfg = BUS_VOLTAGE_RST;
        duty_cap_cfg = MAX_DUTY_RST;
        tx_idle = 0; rx_idle = 0;
        hold_until = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_config_sweep();
        test_idle_phases();
        test_backpressure();
        drain();
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("simulation failed");
        $finish;
    end

endmodule
